// File: rtl/fdrp_pkg.sv
// ----------------------------------------------------------------------------
// fdrp_pkg
// Shared sizes, codes and types for the FIFO with duplicate-run purge.
// ----------------------------------------------------------------------------
package fdrp_pkg;

  // Queue geometry.
  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // Request action codes.
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_GET   = 2'd1;
  localparam logic [1:0] ACT_PURGE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // One result of a request.
  typedef struct packed {
    logic [1:0]       status;
    logic [CW-1:0]    count;
    logic [WIDTH-1:0] dropped;
  } res_t;

endpackage

// File: rtl/fdrp_ram.sv
// ----------------------------------------------------------------------------
// fdrp_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module fdrp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fifo_with_duplicate_run_purge_top.sv
// ----------------------------------------------------------------------------
// fifo_with_duplicate_run_purge_top
// Bounded FIFO in a circular RAM with put, get and a purge that collapses runs
// of equal adjacent entries, compacting the queue in place.
// ----------------------------------------------------------------------------
// Sequence: put, unused codes, a get of an empty queue and a purge of at most
// one entry resolve in the accept cycle; a get reads the head from the RAM and
// returns it from ST_GET; a purge walks the stored entries through the single
// RAM read port in ST_PURGE. One request at a time; new ones enter in ST_IDLE.
// A result register and a one-entry holding register let the next request in
// while a result waits. Reset empties the queue; RAM contents are not cleared.
module fifo_with_duplicate_run_purge_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic signed [31:0]             value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [fdrp_pkg::CW-1:0]        entry_count_o,
  output logic signed [31:0]             dropped_value_o
);

  import fdrp_pkg::*;

  localparam int SW = AW + 1;

  // Controller states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_GET   = 2'd1;
  localparam logic [1:0] ST_PURGE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    rd_idx_q, rd_idx_d;
  logic [CW-1:0]    kept_q, kept_d;
  logic             dv_q, dv_d;
  logic             first_q, first_d;
  logic [WIDTH-1:0] last_q, last_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;
  logic             pend_valid_q, pend_valid_d;
  res_t             pend_q, pend_d;

  logic             in_ok;
  logic             out_free;
  logic             done;
  logic             issue;
  res_t             res;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [WIDTH-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [WIDTH-1:0] ram_rdata;

  // Physical slot of a logical queue position, wrapping around the RAM.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = {1'b0, head} + SW'(pos);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  fdrp_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A request enters only when idle and the holding register is empty.
  assign in_stall_o = (state_q != ST_IDLE) || pend_valid_q;
  assign in_ok      = in_valid_i && !in_stall_o;
  assign issue      = rd_idx_q < count_q;

  // Request processing and the purge walk.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    kept_d      = kept_q;
    dv_d        = 1'b0;
    first_d     = first_q;
    last_d      = last_q;
    done        = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = head_q;
    res.status  = STATUS_OK;
    res.dropped = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_ok) begin
          case (action_i)
            ACT_PUT: begin
              done = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                res.status = STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot(head_q, count_q);
                ram_wdata = value_i[WIDTH-1:0];
                count_d   = count_q + CW'(1);
              end
            end
            ACT_GET: begin
              if (count_q == '0) begin
                done       = 1'b1;
                res.status = STATUS_EMPTY;
              end else begin
                head_d  = slot(head_q, CW'(1));
                count_d = count_q - CW'(1);
                state_d = ST_GET;
              end
            end
            ACT_PURGE: begin
              if (count_q > CW'(1)) begin
                rd_idx_d = CW'(1);
                kept_d   = CW'(1);
                dv_d     = 1'b1;
                first_d  = 1'b1;
                state_d  = ST_PURGE;
              end else begin
                done = 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      ST_GET: begin
        done        = 1'b1;
        res.dropped = ram_rdata;
        state_d     = ST_IDLE;
      end
      ST_PURGE: begin
        // Stream reads ahead; writes land at or behind the current read.
        if (issue) begin
          ram_raddr = slot(head_q, rd_idx_q);
          rd_idx_d  = rd_idx_q + CW'(1);
        end
        dv_d = issue;
        if (dv_q) begin
          if (first_q) begin
            first_d = 1'b0;
            last_d  = ram_rdata;
          end else if (ram_rdata != last_q) begin
            ram_we    = 1'b1;
            ram_waddr = slot(head_q, kept_q);
            ram_wdata = ram_rdata;
            kept_d    = kept_q + CW'(1);
            last_d    = ram_rdata;
          end
        end else if (!issue) begin
          count_d = kept_q;
          done    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    res.count = count_d;
  end

  // Result register with a one-entry holding register behind it.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if (out_free) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = pend_q;
        pend_valid_d = 1'b0;
      end else if (done) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (done) begin
      pend_valid_d = 1'b1;
      pend_d       = res;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      rd_idx_q     <= '0;
      kept_q       <= '0;
      dv_q         <= 1'b0;
      first_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      rd_idx_q     <= rd_idx_d;
      kept_q       <= kept_d;
      dv_q         <= dv_d;
      first_q      <= first_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign entry_count_o   = out_q.count;
  assign dropped_value_o = out_q.dropped;

endmodule
